// ----- src/htlp_pkg.sv -----
// Shared types, constants and helpers for the linear-probing hash table.
package htlp_pkg;

  localparam int SLOTS = 512;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KEY_W = 34;
  localparam int VAL_W = 64;
  localparam int OUT_IDX_W = 9;
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
  localparam int MOD_PAD_W = MOD_STEPS * MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_FOUND     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_KEY_ZERO  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HSTART,
    S_HWAIT,
    S_READ,
    S_CHECK,
    S_OWAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [OUT_IDX_W-1:0] slot;
    logic [VAL_W-1:0]     stored_value;
    logic [OUT_IDX_W-1:0] probes;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] operand;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] result;
  } mod_rsp_t;

  function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [SLOT_W-1:0] i);
    logic [31:0] wide;
    wide = 32'(i);
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// ----- src/htlp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/htlp_mod.sv -----
// Iterative key-modulo-slot-count unit, several remainder bits per cycle.
module htlp_mod (
  input  logic              clk,
  input  logic              rst,
  input  htlp_pkg::mod_req_t req,
  output htlp_pkg::mod_rsp_t rsp
);

  logic                                active;
  logic                                done;
  logic [htlp_pkg::MOD_CNT_W-1:0]      cnt;
  logic [htlp_pkg::MOD_PAD_W-1:0]      shreg;
  logic [htlp_pkg::SLOT_W-1:0]         rem;
  logic [htlp_pkg::SLOT_W-1:0]         rem_next;

  always_comb begin
    logic [htlp_pkg::SLOT_W:0]   t;
    logic [htlp_pkg::SLOT_W-1:0] r;
    r = rem;
    for (int b = 0; b < htlp_pkg::MOD_BITS; b++) begin
      t = {r, shreg[htlp_pkg::MOD_PAD_W-1-b]};
      if (t >= (htlp_pkg::SLOT_W+1)'(htlp_pkg::SLOTS)) begin
        t = t - (htlp_pkg::SLOT_W+1)'(htlp_pkg::SLOTS);
      end
      r = t[htlp_pkg::SLOT_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (htlp_pkg::SLOTS_POW2) begin
          rem  <= req.operand[htlp_pkg::SLOT_W-1:0];
          done <= 1'b1;
        end else begin
          active <= 1'b1;
          cnt    <= '0;
          shreg  <= htlp_pkg::MOD_PAD_W'(req.operand);
          rem    <= '0;
        end
      end else if (active) begin
        shreg <= shreg << htlp_pkg::MOD_BITS;
        rem   <= rem_next;
        cnt   <= cnt + 1'b1;
        if (cnt == htlp_pkg::MOD_CNT_W'(htlp_pkg::MOD_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = rem;

endmodule

// ----- src/hash_table_linear_probe_core.sv -----
// Top level of the open-addressing hash table with linear probing.
// After reset the block sweeps the key store to empty, one slot a cycle, through all
// SLOTS (512) slots before the first transfer is taken; configuration writes are
// honoured throughout. One operation is handled at a time. Each first computes the home
// slot on the shared modulo unit (the low key bits when SLOTS is a power of two, otherwise
// an iterative remainder) and then probes slots; each probe is a read of the key and value
// memories followed by a compare. A search or update of an absent key probes every slot.
// In replacement mode each displaced entry adds a fresh home computation and its own probe
// walk. Zero keys, the unused operation code and inserts into a full table answer without
// a home computation or probe. A finished result waits in an output register while the
// next transfer is taken.
module hash_table_linear_probe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  htlp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output htlp_pkg::out_item_t out_item
);

  htlp_pkg::state_e state;
  htlp_pkg::state_e state_next;

  logic                          replace_mode;
  logic [htlp_pkg::CNT_W-1:0]    entry_count;
  logic [htlp_pkg::SLOT_W-1:0]   idx;
  logic [htlp_pkg::SLOT_W-1:0]   home;
  logic [htlp_pkg::SLOT_W-1:0]   passed;
  logic [htlp_pkg::SLOT_W-1:0]   where;
  logic                          first;
  logic [1:0]                    op;
  logic [htlp_pkg::KEY_W-1:0]    ck;
  logic [htlp_pkg::VAL_W-1:0]    cv;
  logic [htlp_pkg::KEY_W-1:0]    occ_key;
  logic [htlp_pkg::VAL_W-1:0]    occ_val;
  htlp_pkg::status_e             res_status;
  logic [htlp_pkg::SLOT_W-1:0]   res_slot;
  logic [htlp_pkg::VAL_W-1:0]    res_value;
  logic [htlp_pkg::SLOT_W-1:0]   res_probes;

  logic [htlp_pkg::KEY_W-1:0]    key_rd;
  logic [htlp_pkg::VAL_W-1:0]    val_rd;
  logic                          key_we;
  logic [htlp_pkg::KEY_W-1:0]    key_wdata;
  logic                          val_we;

  htlp_pkg::mod_req_t            mod_req;
  htlp_pkg::mod_rsp_t            mod_rsp;

  logic                          accept;
  logic                          key_zero;
  logic                          table_full;
  logic                          is_find;
  logic                          hit;
  logic                          empty;
  logic                          at_home;
  logic                          wrap;
  logic                          displace;
  logic                          clear_last;
  logic                          out_free;
  logic [htlp_pkg::SLOT_W-1:0]   idx_inc;

  htlp_ram #(.WIDTH(htlp_pkg::KEY_W), .DEPTH(htlp_pkg::SLOTS)) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(idx),
    .wdata(key_wdata),
    .raddr(idx),
    .rdata(key_rd)
  );

  htlp_ram #(.WIDTH(htlp_pkg::VAL_W), .DEPTH(htlp_pkg::SLOTS)) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(idx),
    .wdata(cv),
    .raddr(idx),
    .rdata(val_rd)
  );

  htlp_mod u_mod (
    .clk(clk),
    .rst(rst),
    .req(mod_req),
    .rsp(mod_rsp)
  );

  assign accept     = in_valid && in_ready;
  assign key_zero   = (in_item.key == '0);
  assign table_full = (entry_count == htlp_pkg::CNT_W'(htlp_pkg::SLOTS));
  assign is_find    = (op == htlp_pkg::OP_SEARCH) || (op == htlp_pkg::OP_UPDATE);
  assign hit        = (key_rd == ck);
  assign empty      = (key_rd == '0);
  assign at_home    = (idx == home);
  assign idx_inc    = (idx == htlp_pkg::SLOT_W'(htlp_pkg::SLOTS - 1)) ? '0 : idx + 1'b1;
  assign wrap       = (idx_inc == home);
  assign displace   = (mod_rsp.result != home);
  assign clear_last = (idx == htlp_pkg::SLOT_W'(htlp_pkg::SLOTS - 1));
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      htlp_pkg::S_CLEAR: begin
        if (clear_last) begin
          state_next = htlp_pkg::S_IDLE;
        end
      end
      htlp_pkg::S_IDLE: begin
        if (accept) begin
          if (key_zero) begin
            state_next = htlp_pkg::S_RESP;
          end else begin
            case (in_item.op)
              htlp_pkg::OP_INSERT: begin
                state_next = table_full ? htlp_pkg::S_RESP : htlp_pkg::S_HSTART;
              end
              htlp_pkg::OP_SEARCH, htlp_pkg::OP_UPDATE: begin
                state_next = htlp_pkg::S_HSTART;
              end
              default: begin
                state_next = htlp_pkg::S_RESP;
              end
            endcase
          end
        end
      end
      htlp_pkg::S_HSTART: begin
        state_next = htlp_pkg::S_HWAIT;
      end
      htlp_pkg::S_HWAIT: begin
        if (mod_rsp.done) begin
          state_next = htlp_pkg::S_READ;
        end
      end
      htlp_pkg::S_READ: begin
        state_next = htlp_pkg::S_CHECK;
      end
      htlp_pkg::S_CHECK: begin
        if (is_find) begin
          state_next = (hit || wrap) ? htlp_pkg::S_RESP : htlp_pkg::S_READ;
        end else if (empty) begin
          state_next = htlp_pkg::S_RESP;
        end else if (replace_mode && at_home) begin
          state_next = htlp_pkg::S_OWAIT;
        end else begin
          state_next = wrap ? htlp_pkg::S_RESP : htlp_pkg::S_READ;
        end
      end
      htlp_pkg::S_OWAIT: begin
        if (mod_rsp.done) begin
          if (displace) begin
            state_next = htlp_pkg::S_HSTART;
          end else begin
            state_next = wrap ? htlp_pkg::S_RESP : htlp_pkg::S_READ;
          end
        end
      end
      htlp_pkg::S_RESP: begin
        if (out_free) begin
          state_next = htlp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = htlp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    key_we          = 1'b0;
    key_wdata       = ck;
    val_we          = 1'b0;
    mod_req.start   = 1'b0;
    mod_req.operand = ck;
    case (state)
      htlp_pkg::S_CLEAR: begin
        key_we    = 1'b1;
        key_wdata = '0;
      end
      htlp_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      htlp_pkg::S_HSTART: begin
        mod_req.start = 1'b1;
      end
      htlp_pkg::S_CHECK: begin
        if (is_find) begin
          val_we = hit && (op == htlp_pkg::OP_UPDATE);
        end else if (empty) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end else if (replace_mode && at_home) begin
          mod_req.start   = 1'b1;
          mod_req.operand = key_rd;
        end
      end
      htlp_pkg::S_OWAIT: begin
        key_we = mod_rsp.done && displace;
        val_we = mod_rsp.done && displace;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= htlp_pkg::S_CLEAR;
      replace_mode <= 1'b0;
      entry_count  <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        replace_mode <= cfg_wr_data;
      end
      if (state == htlp_pkg::S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        htlp_pkg::S_CLEAR: begin
          idx <= idx_inc;
        end
        htlp_pkg::S_HWAIT: begin
          if (mod_rsp.done) begin
            idx <= mod_rsp.result;
          end
        end
        htlp_pkg::S_CHECK: begin
          if (is_find) begin
            if (!hit) begin
              idx <= idx_inc;
            end
          end else if (empty) begin
            entry_count <= entry_count + 1'b1;
          end else if (!(replace_mode && at_home)) begin
            idx <= idx_inc;
          end
        end
        htlp_pkg::S_OWAIT: begin
          if (mod_rsp.done && !displace) begin
            idx <= idx_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      htlp_pkg::S_IDLE: begin
        if (accept) begin
          op         <= in_item.op;
          ck         <= in_item.key;
          cv         <= in_item.value;
          first      <= 1'b1;
          res_slot   <= '0;
          res_probes <= '0;
          if (key_zero) begin
            res_status <= htlp_pkg::STATUS_KEY_ZERO;
          end else if (in_item.op == htlp_pkg::OP_INSERT) begin
            res_status <= htlp_pkg::STATUS_FULL;
          end else begin
            res_status <= htlp_pkg::STATUS_NOT_FOUND;
          end
          if (in_item.op == htlp_pkg::OP_INSERT && !table_full && !key_zero) begin
            res_value <= in_item.value;
          end else begin
            res_value <= '0;
          end
        end
      end
      htlp_pkg::S_HWAIT: begin
        if (mod_rsp.done) begin
          home   <= mod_rsp.result;
          passed <= '0;
        end
      end
      htlp_pkg::S_CHECK: begin
        if (is_find) begin
          if (hit) begin
            res_status <= htlp_pkg::STATUS_FOUND;
            res_slot   <= idx;
            if (op == htlp_pkg::OP_SEARCH) begin
              res_value  <= val_rd;
              res_probes <= passed;
            end else begin
              res_value <= cv;
            end
          end else begin
            passed <= passed + 1'b1;
          end
        end else if (empty) begin
          res_status <= htlp_pkg::STATUS_INSERTED;
          res_slot   <= first ? idx : where;
        end else if (replace_mode && at_home) begin
          occ_key <= key_rd;
          occ_val <= val_rd;
        end else if (wrap) begin
          res_value <= '0;
        end
      end
      htlp_pkg::S_OWAIT: begin
        if (mod_rsp.done) begin
          if (displace) begin
            if (first) begin
              where <= idx;
            end
            first <= 1'b0;
            ck    <= occ_key;
            cv    <= occ_val;
          end else if (wrap) begin
            res_value <= '0;
          end
        end
      end
      htlp_pkg::S_RESP: begin
        if (out_free) begin
          out_item.status       <= res_status;
          out_item.slot         <= htlp_pkg::out_idx(res_slot);
          out_item.stored_value <= res_value;
          out_item.probes       <= htlp_pkg::out_idx(res_probes);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sim/htlp_probe_checker.sv -----
// Checker for the linear-probing hash table: predicts every reply and compares it on transfer.
module htlp_probe_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  htlp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  htlp_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  reply_count
);
  import htlp_pkg::*;

  bit [KEY_W-1:0] key_mem [SLOTS];
  bit [VAL_W-1:0] val_mem [SLOTS];
  int unsigned    occupied;
  bit             displace_on;
  out_item_t      expected_replies [$];
  out_item_t      oldest;

  initial mismatch_count = 0;

  function automatic int unsigned home_slot(bit [KEY_W-1:0] k);
    return int'(k % SLOTS);
  endfunction

  function automatic bit place_first_free(bit [KEY_W-1:0] k, bit [VAL_W-1:0] v,
                                          output int unsigned where);
    int unsigned h;
    int unsigned i;
    h = home_slot(k);
    i = h;
    where = 0;
    do begin
      if (key_mem[i] == '0) begin
        key_mem[i] = k;
        val_mem[i] = v;
        occupied++;
        where = i;
        return 1'b1;
      end
      i = (i + 1) % SLOTS;
    end while (i != h);
    return 1'b0;
  endfunction

  function automatic bit place_displacing(bit [KEY_W-1:0] k, bit [VAL_W-1:0] v,
                                          output int unsigned where);
    bit [KEY_W-1:0] carry_key;
    bit [VAL_W-1:0] carry_val;
    bit [KEY_W-1:0] resident;
    bit [VAL_W-1:0] resident_val;
    bit             first_round;
    bit             moved;
    int unsigned    h;
    int unsigned    i;
    carry_key = k;
    carry_val = v;
    first_round = 1'b1;
    where = 0;
    for (int round = 0; round <= SLOTS; round++) begin
      h = home_slot(carry_key);
      i = h;
      moved = 1'b0;
      do begin
        resident = key_mem[i];
        if (resident == '0) begin
          key_mem[i] = carry_key;
          val_mem[i] = carry_val;
          occupied++;
          if (first_round) where = i;
          return 1'b1;
        end
        if (i == h && home_slot(resident) != h) begin
          resident_val = val_mem[i];
          key_mem[i] = carry_key;
          val_mem[i] = carry_val;
          if (first_round) where = i;
          first_round = 1'b0;
          carry_key = resident;
          carry_val = resident_val;
          moved = 1'b1;
          break;
        end
        i = (i + 1) % SLOTS;
      end while (i != h);
      if (!moved) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic bit locate(bit [KEY_W-1:0] k, output int unsigned where,
                                output int unsigned passed);
    int unsigned h;
    int unsigned i;
    int unsigned n;
    h = home_slot(k);
    i = h;
    n = 0;
    where = 0;
    passed = 0;
    do begin
      if (key_mem[i] == k) begin
        where = i;
        passed = n;
        return 1'b1;
      end
      i = (i + 1) % SLOTS;
      n++;
    end while (i != h);
    return 1'b0;
  endfunction

  function automatic out_item_t table_response(in_item_t request);
    out_item_t   answer;
    int unsigned where;
    int unsigned passed;
    bit          placed;
    answer.status = STATUS_NOT_FOUND;
    answer.slot = '0;
    answer.stored_value = '0;
    answer.probes = '0;
    where = 0;
    passed = 0;
    placed = 1'b0;
    if (request.key == '0) begin
      answer.status = STATUS_KEY_ZERO;
    end else if (request.op == OP_INSERT) begin
      if (occupied < SLOTS) begin
        if (displace_on) placed = place_displacing(request.key, request.value, where);
        else placed = place_first_free(request.key, request.value, where);
      end
      if (placed) begin
        answer.status = STATUS_INSERTED;
        answer.slot = where[OUT_IDX_W-1:0];
        answer.stored_value = request.value;
      end else begin
        answer.status = STATUS_FULL;
      end
    end else if (request.op == OP_SEARCH) begin
      if (locate(request.key, where, passed)) begin
        answer.status = STATUS_FOUND;
        answer.slot = where[OUT_IDX_W-1:0];
        answer.stored_value = val_mem[where];
        answer.probes = passed[OUT_IDX_W-1:0];
      end
    end else if (request.op == OP_UPDATE) begin
      if (locate(request.key, where, passed)) begin
        val_mem[where] = request.value;
        answer.status = STATUS_FOUND;
        answer.slot = where[OUT_IDX_W-1:0];
        answer.stored_value = request.value;
      end
    end
    return answer;
  endfunction

  task automatic flag(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i] = '0;
        val_mem[i] = '0;
      end
      occupied = 0;
      displace_on = 1'b0;
      expected_replies.delete();
      reply_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        reply_count <= reply_count + 1;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with nothing expected, expected none, got %p", $time, out_item);
          mismatch_count++;
        end else begin
          oldest = expected_replies.pop_front();
          flag("status", 64'(oldest.status), 64'(out_item.status));
          flag("slot", 64'(oldest.slot), 64'(out_item.slot));
          flag("stored_value", oldest.stored_value, out_item.stored_value);
          flag("probes", 64'(oldest.probes), 64'(out_item.probes));
        end
      end
      if (cfg_wr_en) displace_on = cfg_wr_data;
      if (in_valid && in_ready) expected_replies.push_back(table_response(in_item));
    end
  end

endmodule

// ----- sim/hash_table_linear_probe_core_tb.sv -----
// Testbench top for the linear-probing hash table: stimulus, handshake pacing and verdict.
module hash_table_linear_probe_core_tb;
  import htlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [VAL_W-1:0] VAL_TOP = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int          mismatch_count;
  int          reply_count;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  int unsigned inserted = 0;
  int unsigned hot_base = 0;
  bit          calm = 1'b0;
  logic [KEY_W-1:0] stored_keys [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hash_table_linear_probe_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  htlp_probe_checker probe_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .reply_count    (reply_count)
  );

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = {2'($urandom_range(0, 3)), $urandom};
    if ($urandom_range(0, 1)) k[SLOT_W-1:0] = SLOT_W'((hot_base + $urandom_range(0, 23)) % SLOTS);
    if (k == '0) k = 1;
    return k;
  endfunction

  task automatic transfer(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    in_item_t    it;
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    it.op = op;
    it.key = k;
    it.value = v;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    accepted++;
    if (op == OP_INSERT && k != '0 && inserted < SLOTS) begin
      stored_keys.push_back(k);
      inserted++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reply_count != accepted) @(posedge clk);
  endtask

  task automatic set_replace(bit mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_op();
    logic [1:0]       op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (pick < 36) begin
      op = OP_INSERT;
      k = fresh_key();
    end else if (pick < 66 && stored_keys.size() > 0) begin
      op = OP_SEARCH;
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (pick < 81 && stored_keys.size() > 0) begin
      op = OP_UPDATE;
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (pick < 91) begin
      op = $urandom_range(0, 1) ? OP_SEARCH : OP_UPDATE;
      k = fresh_key();
    end else if (pick < 95) begin
      op = 2'($urandom_range(0, 3));
      k = '0;
    end else begin
      op = OP_UNUSED;
      k = fresh_key();
    end
    transfer(op, k, v);
  endtask

  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) > 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_replace(1'b0);

    // Plain insertion: empty table, zero keys, the spare opcode, wrap-around and duplicates.
    transfer(OP_SEARCH, 34'd5, '0);
    transfer(OP_INSERT, '0, VAL_TOP);
    transfer(OP_SEARCH, '0, '0);
    transfer(OP_UPDATE, '0, VAL_TOP);
    transfer(OP_UNUSED, '0, '0);
    transfer(OP_UNUSED, 34'd77, VAL_TOP);
    transfer(OP_INSERT, KEY_TOP, VAL_TOP);
    transfer(OP_INSERT, 34'd511, '0);
    transfer(OP_INSERT, 34'd1023, 64'h0123_4567_89ab_cdef);
    transfer(OP_SEARCH, 34'd1023, '0);
    transfer(OP_INSERT, 34'd1023, 64'hfedc_ba98_7654_3210);
    transfer(OP_SEARCH, 34'd1023, '0);
    transfer(OP_UPDATE, 34'd511, VAL_TOP);
    transfer(OP_SEARCH, 34'd511, '0);
    transfer(OP_UPDATE, 34'd7, VAL_TOP);
    drain();

    // Replacement: keys away from home are pushed out and walk on.
    set_replace(1'b1);
    transfer(OP_INSERT, 34'd1, 64'h1111_0000_1111_0000);
    transfer(OP_SEARCH, 34'd1023, '0);
    transfer(OP_INSERT, 34'd513, 64'h2222_0000_2222_0000);
    transfer(OP_SEARCH, 34'd513, '0);
    transfer(OP_SEARCH, KEY_TOP, '0);
    transfer(OP_INSERT, 34'd512, '0);
    transfer(OP_SEARCH, 34'd511, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      set_replace(phase % 2 == 1);
      calm = (phase == 2);
      hot_base = $urandom_range(0, SLOTS - 1);
      repeat (PHASE_ITEMS) random_op();
      drain();
    end
    calm = 1'b0;

    repeat (2 * SLOTS + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
